// ===== rtl/tkft_pkg.sv =====
package tkft_pkg;

    localparam int TOP_K     = 5;
    localparam int KEY_WIDTH = 64;
    localparam int CNT_W     = 31;
    localparam int PCT_W     = 7;
    localparam int IDX_W     = $clog2(TOP_K + 1);
    // dividend 100*count fits in 38 bits
    localparam int DIVD_W    = 38;
    localparam int DCNT_W    = $clog2(DIVD_W + 1);
    // per-entry quotient can reach 100*(2^31-1): 38 bits; sum of TOP_K of them
    localparam int SUM_W     = DIVD_W + 4;

    localparam logic [PCT_W-1:0] THR_CAP     = PCT_W'(95);
    // smallest sum whose truncated 7/10 lies above the cap
    localparam logic [SUM_W-1:0] THR_SAT_SUM = SUM_W'(138);
    localparam logic [1:0]       REG_MIN_CNT = 2'd0;
    localparam logic [1:0]       REG_MIN_PCT = 2'd1;
    localparam logic [1:0]       REG_DEF_THR = 2'd2;

    localparam logic [CNT_W-1:0] MIN_CNT_RST = CNT_W'(10);
    localparam logic [PCT_W-1:0] MIN_PCT_RST = PCT_W'(50);
    localparam logic [PCT_W-1:0] DEF_THR_RST = PCT_W'(10);

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [30:0] item_count;
        logic [30:0] total_count;
    } req_t;

    typedef struct packed {
        logic       is_top;
        logic       in_table;
        logic [6:0] threshold;
        logic       divide_error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_QDIV,
        ST_QSUM,
        ST_DONE
    } state_t;

    // command broadcast from the controller to the cell row
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_SET,
        CMD_BUBBLE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t              cmd;
        logic [KEY_WIDTH-1:0]   key;
        logic [CNT_W-1:0]       cnt;
        logic [IDX_W-1:0]       pos;
    } cell_ctl_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_WIDTH-1:0] key;
        logic [CNT_W-1:0]     cnt;
    } entry_t;

endpackage

// ===== rtl/tkft_cell.sv =====
// One table slot. Takes part in insert (shift from upper neighbor), in-place set
// and one bubble step between slot pos-1 and pos.
module tkft_cell
    import tkft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     idx,
    input  cell_ctl_t            ctl,
    input  entry_t               upper,
    input  entry_t               lower,
    output entry_t               ent,
    output logic                 hit
);

    logic                 valid_reg, valid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    assign ent.valid = valid_reg;
    assign ent.key   = key_reg;
    assign ent.cnt   = cnt_reg;
    assign hit       = valid_reg && (key_reg == ctl.key);

    // choose next content from command
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        case (ctl.cmd)
            CMD_INSERT:
            begin
                if (idx == ctl.pos)
                begin
                    valid_next = 1'b1;
                    key_next   = ctl.key;
                    cnt_next   = ctl.cnt;
                end
                else if (idx > ctl.pos)
                begin
                    valid_next = upper.valid;
                    key_next   = upper.key;
                    cnt_next   = upper.cnt;
                end
            end
            CMD_SET:
            begin
                if (idx == ctl.pos)
                    cnt_next = ctl.cnt;
            end
            CMD_BUBBLE:
            begin
                // swap pos-1 (upper) with pos (lower) when upper count is smaller
                if (idx == ctl.pos && upper.cnt < cnt_reg)
                begin
                    valid_next = upper.valid;
                    key_next   = upper.key;
                    cnt_next   = upper.cnt;
                end
                else if (idx + IDX_W'(1) == ctl.pos && cnt_reg < lower.cnt)
                begin
                    valid_next = lower.valid;
                    key_next   = lower.key;
                    cnt_next   = lower.cnt;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            key_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            key_reg   <= key_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/tkft_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tkft_div
    import tkft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIVD_W-1:0]    dividend,
    input  logic [CNT_W-1:0]     divisor,
    output logic                 done,
    output logic [DIVD_W-1:0]    quotient
);

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVD_W-1:0] q_reg, q_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    trial;

    assign done     = done_reg;
    assign quotient = q_reg;

    // shift in one dividend bit, try subtract
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg[CNT_W-1:0], q_reg[DIVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIVD_W);
            q_next    = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                q_next   = {q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ===== rtl/top_k_frequency_tracker_unit.sv =====
// Top-K tracker: a row of TOP_K cells holds (key, count) sorted high to low.
// One request in flight at a time. An update of a held key runs one bubble
// step per slot above it. A query walks the entries on one serial divider,
// one division per entry; updates without bubble steps, and queries with
// unknown keys or zero totals, go straight to the done state.
// The result waits in an output register; a request whose result finds that
// register still full holds until it is handed off.
module top_k_frequency_tracker_unit
    import tkft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  req_t         in_data,
    output logic         out_valid,
    input  logic         out_stall,
    output rsp_t         out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     min_cnt_reg;
    logic [PCT_W-1:0]     min_pct_reg;
    logic [PCT_W-1:0]     def_thr_reg;
    logic [PCT_W-1:0]     thr_reg, thr_next;
    req_t                 req_reg;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 ov_reg, ov_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 top_reg, top_next;
    logic                 derr_reg, derr_next;
    logic                 kick_reg;

    cell_ctl_t            ctl;
    entry_t               ents [TOP_K];
    logic [TOP_K-1:0]     hits;
    logic                 found;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     ins_idx;
    logic                 div_start, div_done;
    logic [DIVD_W-1:0]    quot;
    logic [DIVD_W-1:0]    dvd;
    logic [IDX_W-1:0]     dvd_pos;
    logic [SUM_W-1:0]     sum_add;
    logic [10:0]          t7;
    logic [17:0]          t7_div;
    logic [PCT_W-1:0]     thr_calc;
    logic [1:0]           reg_idx;
    logic                 in_acc;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign in_acc  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cnt_reg <= MIN_CNT_RST;
            min_pct_reg <= MIN_PCT_RST;
            def_thr_reg <= DEF_THR_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_MIN_CNT: min_cnt_reg <= pwdata[CNT_W-1:0];
                REG_MIN_PCT: min_pct_reg <= pwdata[PCT_W-1:0];
                REG_DEF_THR: def_thr_reg <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_CNT: prdata = 32'(min_cnt_reg);
            REG_MIN_PCT: prdata = 32'(min_pct_reg);
            REG_DEF_THR: prdata = 32'(def_thr_reg);
            default:     prdata = '0;
        endcase
    end

    // cell row
    for (genvar g = 0; g < TOP_K; g++)
    begin : g_cell
        entry_t up, dn;
        if (g == 0)
        begin : g_first
            assign up = '0;
        end
        else
        begin : g_up
            assign up = ents[g-1];
        end
        if (g == TOP_K - 1)
        begin : g_last
            assign dn = '0;
        end
        else
        begin : g_dn
            assign dn = ents[g+1];
        end
        tkft_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .idx   (IDX_W'(g)),
            .ctl   (ctl),
            .upper (up),
            .lower (dn),
            .ent   (ents[g]),
            .hit   (hits[g])
        );
    end

    // locate key and insert point
    always_comb
    begin
        found   = |hits;
        hit_idx = '0;
        ins_idx = IDX_W'(TOP_K);
        for (int i = TOP_K - 1; i >= 0; i--)
        begin
            if (hits[i])
                hit_idx = IDX_W'(i);
            if (req_reg.item_count > ents[i].cnt)
                ins_idx = IDX_W'(i);
        end
    end

    // dividend for the entry the next division works on
    assign dvd_pos = (pos_next < IDX_W'(TOP_K)) ? pos_next : '0;
    assign dvd     = DIVD_W'(ents[dvd_pos].cnt) * DIVD_W'(100);

    tkft_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (req_reg.total_count),
        .done     (div_done),
        .quotient (quot)
    );

    assign sum_add = sum_reg + SUM_W'(quot);

    // 7*sum/10 below the cap: divide by 10 through a reciprocal multiply
    assign t7       = 11'(sum_reg[7:0]) * 11'(7);
    assign t7_div   = 18'(t7) * 18'(205);
    assign thr_calc = t7_div[17:11];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        thr_next   = thr_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        ov_next    = ov_reg;
        rsp_next   = rsp_reg;
        top_next   = top_reg;
        derr_next  = derr_reg;
        div_start  = 1'b0;
        ctl.cmd    = CMD_NONE;
        ctl.key    = req_reg.key[KEY_WIDTH-1:0];
        ctl.cnt    = req_reg.item_count;
        ctl.pos    = pos_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    top_next  = 1'b0;
                    derr_next = 1'b0;
                    if (in_data.mode)
                        state_next = ST_QDIV;
                    else
                        state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_DONE;
                if (req_reg.item_count >= min_cnt_reg &&
                    req_reg.item_count > ents[TOP_K-1].cnt)
                begin
                    if (found)
                    begin
                        ctl.cmd = CMD_SET;
                        ctl.pos = hit_idx;
                        pos_next = hit_idx;
                        if (hit_idx != '0)
                            state_next = ST_QSUM;
                    end
                    else
                    begin
                        ctl.cmd = CMD_INSERT;
                        ctl.pos = ins_idx;
                    end
                end
            end
            ST_QSUM:
            begin
                // bubble step between pos-1 and pos, used only by updates
                ctl.cmd  = CMD_BUBBLE;
                pos_next = pos_reg - IDX_W'(1);
                if (pos_reg == IDX_W'(1))
                    state_next = ST_DONE;
            end
            ST_QDIV:
            begin
                if (req_reg.total_count == '0)
                begin
                    derr_next  = 1'b1;
                    thr_next   = def_thr_reg;
                    state_next = ST_DONE;
                end
                else if (!found)
                begin
                    thr_next   = def_thr_reg;
                    state_next = ST_DONE;
                end
                else if (pos_reg == IDX_W'(TOP_K))
                begin
                    thr_next   = def_thr_reg;
                    state_next = ST_DONE;
                end
                else if (kick_reg)
                begin
                    // first division on entry 0
                    div_start = 1'b1;
                end
                else if (div_done)
                begin
                    sum_next = sum_add;
                    pos_next = pos_reg + IDX_W'(1);
                    if (sum_add >= SUM_W'(min_pct_reg))
                    begin
                        top_next = 1'b1;
                        // threshold finished in ST_DONE
                        state_next = ST_DONE;
                    end
                    else if (pos_reg != IDX_W'(TOP_K - 1))
                        div_start = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (top_reg && req_reg.mode && !derr_reg)
                begin
                    if (sum_reg >= THR_SAT_SUM)
                        thr_next = THR_CAP;
                    else
                        thr_next = thr_calc;
                end
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    rsp_next.is_top       = top_reg;
                    rsp_next.in_table     = found;
                    rsp_next.threshold    = thr_next;
                    rsp_next.divide_error = derr_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg   <= DEF_THR_RST;
            ov_reg    <= 1'b0;
            top_reg   <= 1'b0;
            derr_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg   <= (state_reg == ST_DONE && !ov_next) ? thr_reg : thr_next;
            ov_reg    <= ov_next;
            top_reg   <= top_next;
            derr_reg  <= derr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (in_acc)
        begin
            req_reg <= in_data;
            sum_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            pos_reg <= pos_next;
        end
    end

    // kick the first division in the cycle after accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kick_reg <= 1'b0;
        else
            kick_reg <= in_acc && in_data.mode && (in_data.total_count != '0);
    end

    assign out_valid = ov_reg;
    assign out_data  = rsp_reg;

endmodule

// ===== rtl/tkft_checker.sv =====
module tkft_checker
    import tkft_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input rsp_t out_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // a stalled request stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("request withdrawn under stall");

    // a divide error is never reported as top
    a_err_not_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_error |-> !out_data.is_top)
        else $error("divide error reported as top");

    // top implies the key is held
    a_top_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_top |-> out_data.in_table)
        else $error("top without table entry");

    // top threshold never exceeds the cap
    a_thr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_top |-> out_data.threshold <= THR_CAP)
        else $error("threshold above cap");

endmodule

bind top_k_frequency_tracker_unit tkft_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
